>>> design/spq_pkg.sv
// Package with the beat types, status codes and constants of the sorted priority queue.
package spq_pkg;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    localparam logic signed [31:0] EMPTY_VALUE = -32'sd999;
    localparam int unsigned OCC_W = 5;

    typedef struct packed {
        op_t                operation;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        status_t            status;
        logic [OCC_W-1:0]   occupancy;
    } result_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t item;
    } cell_cmd_t;

endpackage

>>> design/spq_cell.sv
// One queue cell: holds an entry and shifts toward or away from the head.
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cell_cmd,
    input  entry_t    left_ent,
    input  entry_t    right_ent,
    input  logic      left_keep,
    input  logic      in_use,
    output entry_t    ent,
    output logic      keep
);

    entry_t ent_reg;
    entry_t ent_next;

    // An occupied cell whose priority is not above the new one stays put on an insert.
    assign keep = in_use && (ent_reg.prio <= cell_cmd.item.prio);
    assign ent  = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (cell_cmd.enq && !keep)
        begin
            ent_next = left_keep ? cell_cmd.item : left_ent;
        end
        else if (cell_cmd.deq)
        begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

>>> design/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of compare-and-shift cells and a count.
// The result beat is registered: it appears in the cycle after the command is taken.
// Throughput: one command per cycle; busy stays low, and all cells update together.
// Reset clears the entry count and the result strobe; the cell contents are left as they are.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    result_t       result_reg;
    result_t       result_next;
    logic          accept;
    logic          is_full;
    logic          is_empty;
    cell_cmd_t     cell_cmd;
    entry_t        ents  [CAPACITY];
    logic          keeps [CAPACITY];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        cell_cmd.enq  = accept && (cmd.operation == OP_ENQ) && !is_full;
        cell_cmd.deq  = accept && (cmd.operation == OP_DEQ) && !is_empty;
        cell_cmd.item.value = cmd.item_value;
        cell_cmd.item.prio  = cmd.item_priority;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_ent;
        entry_t right_ent;
        logic   left_keep;

        if (i == 0)
        begin : g_head
            assign left_ent  = ents[i];
            assign left_keep = 1'b1;
        end
        else
        begin : g_body
            assign left_ent  = ents[i-1];
            assign left_keep = keeps[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_ent = ents[i];
        end
        else
        begin : g_inner
            assign right_ent = ents[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .cell_cmd  (cell_cmd),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .left_keep (left_keep),
            .in_use    (CW'(i) < count_reg),
            .ent       (ents[i]),
            .keep      (keeps[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cell_cmd.enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cell_cmd.deq)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        result_next.out_value = '0;
        result_next.occupancy = OCC_W'(count_next);
        case (cmd.operation)
            OP_ENQ:
            begin
                result_next.status = is_full ? ST_FULL : ST_ENQ;
            end
            OP_DEQ:
            begin
                if (is_empty)
                begin
                    result_next.out_value = EMPTY_VALUE;
                    result_next.status    = ST_EMPTY;
                end
                else
                begin
                    result_next.out_value = ents[0].value;
                    result_next.status    = ST_DEQ;
                end
            end
            default:
            begin
                result_next.status = ST_ENQ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // The count can never pass the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Every accepted command yields exactly one result beat in the next cycle.
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing result beat");

    // A dropped enqueue leaves the count unchanged.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.operation == OP_ENQ && is_full) |=> $stable(count_reg))
        else $error("count changed on a dropped enqueue");

    // The reported occupancy matches the count after the command.
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.occupancy == OCC_W'(count_reg)))
        else $error("occupancy does not match the entry count");

endmodule
